### sv/lbbc_pkg.sv
`default_nettype none
package lbbc_pkg;

   localparam int KEY_BITS    = 32;
   localparam int SIZE_BITS   = 32;
   localparam int TIME_BITS   = 48;
   localparam int USES_BITS   = 32;
   localparam int BUDGET_BITS = 40;
   localparam int AGE_BITS    = 32;
   localparam int LIMIT_BITS  = 42;
   localparam int SLOT_BITS   = 6;
   localparam int COUNT_BITS  = 7;

   localparam logic [BUDGET_BITS-1:0] BUDGET_RESET = 40'd104857600;
   localparam logic [9:0]             MS_PER_S     = 10'd1000;

   localparam logic [2:0] OP_LOOKUP   = 3'd0;
   localparam logic [2:0] OP_INSERT   = 3'd1;
   localparam logic [2:0] OP_REMOVE   = 3'd2;
   localparam logic [2:0] OP_CLEAR    = 3'd3;
   localparam logic [2:0] OP_EXPIRE   = 3'd4;
   localparam logic [2:0] OP_TRIM     = 3'd5;
   // spare codes: no effect, plain ok result
   localparam logic [2:0] OP_UNUSED_A = 3'd6;
   localparam logic [2:0] OP_UNUSED_B = 3'd7;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_MISS  = 2'd1;
   localparam logic [1:0] ST_NOFIT = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [2:0]           opcode;
      logic [KEY_BITS-1:0]  key;
      logic [SIZE_BITS-1:0] object_bytes;
      logic [TIME_BITS-1:0] now_ms;
      logic [AGE_BITS-1:0]  max_age_s;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic                   hit;
      logic [SLOT_BITS-1:0]   slot;
      logic [COUNT_BITS-1:0]  evicted_count;
      logic [BUDGET_BITS-1:0] used_bytes;
      logic [COUNT_BITS-1:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]  key;
      logic [SIZE_BITS-1:0] bytes;
      logic [TIME_BITS-1:0] insert_time;
      logic [USES_BITS-1:0] uses;
      logic [TIME_BITS-1:0] last_use;
   } row_type;

endpackage
`default_nettype wire

### sv/lfu_byte_budget_cache_table_unit.sv
`default_nettype none
// LFU cache table under a byte budget. One command beat is taken when start is
// high and busy is low; exactly one result beat follows on rsp_valid for a
// single cycle, and the receiver cannot stall it. Entry rows live in a
// memory with one read and one write port, scanned one entry per cycle:
// clear and unused opcodes answer straight from idle; lookup and remove
// scan for the key; expire forms the age limit, then scans every entry;
// insert scans for the key, checks the budget (turning trimming on if the
// object does not fit), evicts victims found by a full scan each, then
// searches for a free slot; trim checks the budget and evicts likewise.
// The result beat is registered and appears when busy has already dropped.
// The budget register may be written at any time through csr_valid but must
// only change while the block is idle.
module lfu_byte_budget_cache_table_unit #(
   parameter int ENTRIES = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire lbbc_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   output lbbc_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lbbc_pkg::BUDGET_BITS-1:0]    csr_data
);

   localparam int IW   = $clog2(ENTRIES);
   localparam int CNTW = $clog2(ENTRIES + 1);
   localparam int SB   = lbbc_pkg::SLOT_BITS;
   localparam int CB   = lbbc_pkg::COUNT_BITS;
   localparam int BB   = lbbc_pkg::BUDGET_BITS;
   localparam int TB   = lbbc_pkg::TIME_BITS;
   localparam int LB   = lbbc_pkg::LIMIT_BITS;
   localparam int UB   = lbbc_pkg::USES_BITS;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_FIND   = 8'b0000_0010,
      S_BUDGET = 8'b0000_0100,
      S_VSCAN  = 8'b0000_1000,
      S_EVICT  = 8'b0001_0000,
      S_SLOT   = 8'b0010_0000,
      S_MULT   = 8'b0100_0000,
      S_EXPIRE = 8'b1000_0000
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [BB-1:0]      total_ff, total_in;
   logic [CNTW-1:0]    count_ff, count_in;
   logic [BB-1:0]      budget_ff, budget_in;
   logic               strobe_ff, strobe_in;
   logic [IW:0]        issue_ff, issue_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               trim_on_ff, trim_on_in;
   logic               vfound_ff, vfound_in;

   // payload
   lbbc_pkg::req_type  req_ff, req_in;
   logic [IW-1:0]      rd_idx_ff, rd_idx_in;
   logic [1:0]         status_ff, status_in;
   logic               hit_ff, hit_in;
   logic [SB-1:0]      slot_ff, slot_in;
   logic [CNTW-1:0]    evicted_ff, evicted_in;
   logic [UB-1:0]      best_uses_ff, best_uses_in;
   logic [TB-1:0]      best_last_ff, best_last_in;
   logic [IW-1:0]      best_slot_ff, best_slot_in;
   logic [lbbc_pkg::SIZE_BITS-1:0] best_bytes_ff, best_bytes_in;
   logic [LB-1:0]      limit_ff, limit_in;
   logic [IW-1:0]      fs_ff, fs_in;

   // row memory
   lbbc_pkg::row_type  mem [ENTRIES];
   lbbc_pkg::row_type  mem_q_ff;
   lbbc_pkg::row_type  mem_wd;
   logic               mem_we;
   logic [IW-1:0]      mem_wa;
   logic [IW-1:0]      rd_addr;

   logic               scan_en;
   logic               scan_stop;
   logic               last;
   logic               match;
   logic               better;
   logic               over_budget;
   logic               no_fit;
   logic [TB-1:0]      age;
   logic               stale;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = strobe_ff;

   always_comb begin
      rsp_data.status        = status_ff;
      rsp_data.hit           = hit_ff;
      rsp_data.slot          = slot_ff;
      rsp_data.evicted_count = CB'(evicted_ff);
      rsp_data.used_bytes    = total_ff;
      rsp_data.entry_count   = CB'(count_ff);
   end

   assign last  = rd_vld_ff && (rd_idx_ff == IW'(ENTRIES - 1));
   assign match = rd_vld_ff && valid_ff[rd_idx_ff] && (mem_q_ff.key == req_ff.key);
   assign better = !vfound_ff || (mem_q_ff.uses < best_uses_ff) ||
                   ((mem_q_ff.uses == best_uses_ff) && (mem_q_ff.last_use < best_last_ff));
   assign over_budget = total_ff > budget_ff;
   assign no_fit = ({1'b0, total_ff} + (BB + 1)'(req_ff.object_bytes)) > {1'b0, budget_ff};
   assign age    = req_ff.now_ms - mem_q_ff.insert_time;
   assign stale  = rd_vld_ff && valid_ff[rd_idx_ff] &&
                   (req_ff.now_ms >= mem_q_ff.insert_time) && (age > TB'(limit_ff));

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      total_in      = total_ff;
      count_in      = count_ff;
      budget_in     = budget_ff;
      strobe_in     = 1'b0;
      issue_in      = issue_ff;
      rd_vld_in     = 1'b0;
      trim_on_in    = trim_on_ff;
      vfound_in     = vfound_ff;
      req_in        = req_ff;
      rd_idx_in     = rd_idx_ff;
      status_in     = status_ff;
      hit_in        = hit_ff;
      slot_in       = slot_ff;
      evicted_in    = evicted_ff;
      best_uses_in  = best_uses_ff;
      best_last_in  = best_last_ff;
      best_slot_in  = best_slot_ff;
      best_bytes_in = best_bytes_ff;
      limit_in      = limit_ff;
      fs_in         = fs_ff;
      mem_we        = 1'b0;
      mem_wa        = rd_idx_ff;
      mem_wd        = mem_q_ff;
      rd_addr       = issue_ff[IW-1:0];
      scan_stop     = 1'b0;

      if (csr_valid) begin
         budget_in = csr_data;
      end

      // issue one read per cycle while scanning
      scan_en = (state_ff == S_FIND) || (state_ff == S_VSCAN) || (state_ff == S_EXPIRE);
      if (scan_en && (issue_ff < (IW + 1)'(ENTRIES))) begin
         issue_in  = issue_ff + (IW + 1)'(1);
         rd_vld_in = 1'b1;
         rd_idx_in = issue_ff[IW-1:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in     = req_data;
               status_in  = lbbc_pkg::ST_OK;
               hit_in     = 1'b0;
               slot_in    = '0;
               evicted_in = '0;
               trim_on_in = 1'b0;
               case (req_data.opcode)
                  lbbc_pkg::OP_LOOKUP,
                  lbbc_pkg::OP_INSERT,
                  lbbc_pkg::OP_REMOVE: state_in = S_FIND;
                  lbbc_pkg::OP_CLEAR: begin
                     evicted_in = count_ff;
                     valid_in   = '0;
                     total_in   = '0;
                     count_in   = '0;
                     strobe_in  = 1'b1;
                  end
                  lbbc_pkg::OP_EXPIRE: state_in = S_MULT;
                  lbbc_pkg::OP_TRIM: begin
                     trim_on_in = 1'b1;
                     state_in   = S_BUDGET;
                  end
                  default: strobe_in = 1'b1;
               endcase
            end
         end
         S_FIND: begin
            if (match) begin
               hit_in    = 1'b1;
               scan_stop = 1'b1;
               case (req_ff.opcode)
                  lbbc_pkg::OP_LOOKUP: begin
                     slot_in = SB'(rd_idx_ff);
                     mem_we  = 1'b1;
                     if (mem_q_ff.uses != '1) begin
                        mem_wd.uses = mem_q_ff.uses + UB'(1);
                     end
                     mem_wd.last_use = req_ff.now_ms;
                     strobe_in = 1'b1;
                     state_in  = S_IDLE;
                  end
                  lbbc_pkg::OP_INSERT: begin
                     valid_in[rd_idx_ff] = 1'b0;
                     total_in = total_ff - BB'(mem_q_ff.bytes);
                     count_in = count_ff - CNTW'(1);
                     state_in = S_BUDGET;
                  end
                  default: begin
                     slot_in    = SB'(rd_idx_ff);
                     valid_in[rd_idx_ff] = 1'b0;
                     total_in   = total_ff - BB'(mem_q_ff.bytes);
                     count_in   = count_ff - CNTW'(1);
                     evicted_in = CNTW'(1);
                     strobe_in  = 1'b1;
                     state_in   = S_IDLE;
                  end
               endcase
            end else if (last) begin
               scan_stop = 1'b1;
               if (req_ff.opcode == lbbc_pkg::OP_INSERT) begin
                  state_in = S_BUDGET;
               end else begin
                  status_in = lbbc_pkg::ST_MISS;
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end
            end
         end
         S_BUDGET: begin
            if (trim_on_ff && over_budget && (count_ff != '0)) begin
               vfound_in = 1'b0;
               state_in  = S_VSCAN;
            end else if (req_ff.opcode != lbbc_pkg::OP_INSERT) begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else if (no_fit) begin
               if (!trim_on_ff) begin
                  trim_on_in = 1'b1;
               end else begin
                  status_in = lbbc_pkg::ST_NOFIT;
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end
            end else if (count_ff == CNTW'(ENTRIES)) begin
               status_in = lbbc_pkg::ST_FULL;
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               fs_in    = '0;
               state_in = S_SLOT;
            end
         end
         S_VSCAN: begin
            if (rd_vld_ff && valid_ff[rd_idx_ff] && better) begin
               vfound_in     = 1'b1;
               best_uses_in  = mem_q_ff.uses;
               best_last_in  = mem_q_ff.last_use;
               best_slot_in  = rd_idx_ff;
               best_bytes_in = mem_q_ff.bytes;
            end
            if (last) begin
               scan_stop = 1'b1;
               state_in  = S_EVICT;
            end
         end
         S_EVICT: begin
            valid_in[best_slot_ff] = 1'b0;
            total_in   = total_ff - BB'(best_bytes_ff);
            count_in   = count_ff - CNTW'(1);
            evicted_in = evicted_ff + CNTW'(1);
            state_in   = S_BUDGET;
         end
         S_SLOT: begin
            if (!valid_ff[fs_ff]) begin
               mem_we             = 1'b1;
               mem_wa             = fs_ff;
               mem_wd.key         = req_ff.key;
               mem_wd.bytes       = req_ff.object_bytes;
               mem_wd.insert_time = req_ff.now_ms;
               mem_wd.uses        = UB'(1);
               mem_wd.last_use    = req_ff.now_ms;
               valid_in[fs_ff]    = 1'b1;
               total_in  = total_ff + BB'(req_ff.object_bytes);
               count_in  = count_ff + CNTW'(1);
               slot_in   = SB'(fs_ff);
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               fs_in = fs_ff + IW'(1);
            end
         end
         S_MULT: begin
            limit_in = LB'(req_ff.max_age_s) * LB'(lbbc_pkg::MS_PER_S);
            state_in = S_EXPIRE;
         end
         S_EXPIRE: begin
            if (stale) begin
               valid_in[rd_idx_ff] = 1'b0;
               total_in   = total_ff - BB'(mem_q_ff.bytes);
               count_in   = count_ff - CNTW'(1);
               evicted_in = evicted_ff + CNTW'(1);
            end
            if (last) begin
               scan_stop = 1'b1;
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // drop reads still in flight when a scan ends
      if (scan_stop) begin
         issue_in  = '0;
         rd_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         valid_ff   <= '0;
         total_ff   <= '0;
         count_ff   <= '0;
         budget_ff  <= lbbc_pkg::BUDGET_RESET;
         strobe_ff  <= 1'b0;
         issue_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         trim_on_ff <= 1'b0;
         vfound_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         total_ff   <= total_in;
         count_ff   <= count_in;
         budget_ff  <= budget_in;
         strobe_ff  <= strobe_in;
         issue_ff   <= issue_in;
         rd_vld_ff  <= rd_vld_in;
         trim_on_ff <= trim_on_in;
         vfound_ff  <= vfound_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      rd_idx_ff     <= rd_idx_in;
      status_ff     <= status_in;
      hit_ff        <= hit_in;
      slot_ff       <= slot_in;
      evicted_ff    <= evicted_in;
      best_uses_ff  <= best_uses_in;
      best_last_ff  <= best_last_in;
      best_slot_ff  <= best_slot_in;
      best_bytes_ff <= best_bytes_in;
      limit_ff      <= limit_in;
      fs_ff         <= fs_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mem[rd_addr];
   end

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while busy");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted command neither busy nor answered");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNTW'($countones(valid_ff)))
      else $error("entry count out of step with valid bits");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(ENTRIES))
      else $error("entry count above table size");

endmodule
`default_nettype wire
